>>> rtl/lzd_pkg.sv
// Shared types, constants and a helper function for the LZSS de-whitening decompressor.
package lzd_pkg;

    localparam int unsigned HIST_DEPTH = 65536;
    localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
    localparam int unsigned OUT_LANES  = 8;
    localparam int unsigned SIZE_W     = 30;
    localparam int unsigned LEN_W      = 9;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [31:0] KS_DEFAULT = 32'h9e37_79b9;
    localparam logic [8:0]  MIN_MATCH  = 9'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_EXP_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITEN   = 2'd2;

    typedef enum logic [2:0] {
        ST_DATA     = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_TRUNC    = 3'd2,
        ST_BADREF   = 3'd3,
        ST_OVERLONG = 3'd4,
        ST_UNEXP    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        COND_ACTIVE = 2'd0,
        COND_DONE   = 2'd1,
        COND_ERROR  = 2'd2
    } t_cond;

    typedef enum logic [1:0] {
        PH_TOKEN  = 2'd0,
        PH_OFF_HI = 2'd1,
        PH_LENGTH = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RD   = 2'd1,
        S_WR   = 2'd2,
        S_FIN  = 2'd3
    } t_bstate;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_qitem;

    typedef struct packed {
        logic               we;
        logic [HIST_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [HIST_AW-1:0] raddr;
    } t_ram_req;

    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

endpackage

>>> rtl/lzd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lzd_front.sv
// Input stage: keystream generation and, when enabled, de-whitening of each accepted byte.
module lzd_front
    import lzd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    input  logic        i_first,
    input  logic        i_last,
    output logic        o_ready,
    input  logic [31:0] i_seed,
    input  logic        i_whiten,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_qitem      o_q_item
);

    logic [31:0] r_ks;
    logic [31:0] n_ks;
    logic [31:0] w_start;

    assign o_ready  = !i_q_full;
    assign o_q_push = i_valid && !i_q_full;
    assign w_start  = i_first ? ((i_seed != 32'd0) ? i_seed : KS_DEFAULT) : r_ks;
    assign n_ks     = xorshift32(w_start);

    always_comb begin
        o_q_item.data  = i_whiten ? (i_byte ^ n_ks[31:24]) : i_byte;
        o_q_item.first = i_first;
        o_q_item.last  = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ks <= KS_DEFAULT;
        end else if (o_q_push) begin
            r_ks <= n_ks;
        end
    end

endmodule

>>> rtl/lzd_queue.sv
// Two-entry queue between the input stage and the decoder.
module lzd_queue
    import lzd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qitem i_item,
    output logic   o_full,
    output logic   o_valid,
    output t_qitem o_item,
    input  logic   i_pop
);

    t_qitem     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

>>> rtl/lzd_back.sv
// Decoder: LZSS token handling, history copy, result packing and stream status.
module lzd_back
    import lzd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_qitem            i_q_item,
    output logic              o_q_pop,
    input  logic [SIZE_W-1:0] i_exp_size,
    output t_ram_req          o_ram,
    input  logic [7:0]        i_ram_rdata,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [63:0]       o_bytes,
    output logic [3:0]        o_count,
    output t_status           o_status,
    output logic              o_last
);

    t_bstate           r_state, n_state;
    logic [SIZE_W-1:0] r_prod, n_prod;
    logic [7:0]        r_flags, n_flags;
    logic [3:0]        r_tok, n_tok;
    t_phase            r_phase, n_phase;
    logic [15:0]       r_off, n_off;
    t_cond             r_cond, n_cond;
    logic [LEN_W-1:0]  r_len, n_len;
    t_status           r_term, n_term;
    logic              r_ilast, n_ilast;
    logic [63:0]       r_acc, n_acc;
    logic [3:0]        r_cnt, n_cnt;
    logic              r_ov, n_ov;
    logic [63:0]       r_ob, n_ob;
    logic [3:0]        r_oc, n_oc;
    t_status           r_os, n_os;
    logic              r_ol, n_ol;

    logic              w_free;
    logic [SIZE_W-1:0] v_prod;
    logic [7:0]        v_flags;
    logic [3:0]        v_tok;
    t_phase            v_phase;
    logic [15:0]       v_off;
    t_cond             v_cond;
    logic              v_copy;
    logic              v_lit;
    logic [LEN_W-1:0]  v_len;
    logic [SIZE_W:0]   v_end;
    logic [63:0]       v_acc;
    logic [3:0]        v_cnt;

    assign w_free   = !r_ov || i_ready;
    assign o_valid  = r_ov;
    assign o_bytes  = r_ob;
    assign o_count  = r_oc;
    assign o_status = r_os;
    assign o_last   = r_ol;

    always_comb begin
        n_state = r_state;
        n_prod  = r_prod;
        n_flags = r_flags;
        n_tok   = r_tok;
        n_phase = r_phase;
        n_off   = r_off;
        n_cond  = r_cond;
        n_len   = r_len;
        n_term  = r_term;
        n_ilast = r_ilast;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_ov    = r_ov && !i_ready;
        n_ob    = r_ob;
        n_oc    = r_oc;
        n_os    = r_os;
        n_ol    = r_ol;
        o_q_pop = 1'b0;
        o_ram   = '0;
        v_prod  = r_prod;
        v_flags = r_flags;
        v_tok   = r_tok;
        v_phase = r_phase;
        v_off   = r_off;
        v_cond  = r_cond;
        v_copy  = 1'b0;
        v_lit   = 1'b0;
        v_len   = '0;
        v_end   = '0;
        v_acc   = '0;
        v_cnt   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.first) begin
                        v_prod  = '0;
                        v_flags = '0;
                        v_tok   = 4'd8;
                        v_phase = PH_TOKEN;
                        v_off   = '0;
                        v_cond  = COND_ACTIVE;
                    end
                    n_prod  = v_prod;
                    n_flags = v_flags;
                    n_tok   = v_tok;
                    n_phase = v_phase;
                    n_off   = v_off;
                    n_cond  = v_cond;
                    n_ilast = i_q_item.last;
                    n_acc   = '0;
                    n_cnt   = '0;
                    if (v_cond == COND_ACTIVE) begin
                        if (v_prod >= i_exp_size) begin
                            n_cond  = COND_ERROR;
                            n_term  = ST_UNEXP;
                            n_state = S_FIN;
                        end else begin
                            if (v_phase == PH_TOKEN) begin
                                if (v_tok >= 4'd8) begin
                                    n_flags = i_q_item.data;
                                    n_tok   = 4'd0;
                                end else if (v_flags[v_tok[2:0]]) begin
                                    n_off   = {8'd0, i_q_item.data};
                                    n_phase = PH_OFF_HI;
                                end else begin
                                    o_ram.we    = 1'b1;
                                    o_ram.waddr = v_prod[HIST_AW-1:0];
                                    o_ram.wdata = i_q_item.data;
                                    n_prod      = v_prod + SIZE_W'(1);
                                    n_acc       = {56'd0, i_q_item.data};
                                    n_cnt       = 4'd1;
                                    n_tok       = v_tok + 4'd1;
                                    v_lit       = 1'b1;
                                end
                            end else if (v_phase == PH_OFF_HI) begin
                                n_off   = {i_q_item.data, v_off[7:0]};
                                n_phase = PH_LENGTH;
                            end else begin
                                v_len   = {1'b0, i_q_item.data} + MIN_MATCH;
                                v_end   = {1'b0, v_prod} + (SIZE_W+1)'(v_len);
                                n_phase = PH_TOKEN;
                                n_tok   = v_tok + 4'd1;
                                v_copy  = 1'b1;
                                if (v_off == 16'd0 || SIZE_W'(v_off) > v_prod) begin
                                    n_cond  = COND_ERROR;
                                    n_term  = ST_BADREF;
                                    n_state = S_FIN;
                                end else if (v_end > {1'b0, i_exp_size}) begin
                                    n_cond  = COND_ERROR;
                                    n_term  = ST_OVERLONG;
                                    n_state = S_FIN;
                                end else begin
                                    n_len   = v_len;
                                    n_state = S_RD;
                                end
                            end
                            if (!v_copy) begin
                                if (n_prod == i_exp_size) begin
                                    n_cond  = COND_DONE;
                                    n_term  = ST_COMPLETE;
                                    n_state = S_FIN;
                                end else if (i_q_item.last) begin
                                    n_cond  = COND_ERROR;
                                    n_term  = ST_TRUNC;
                                    n_state = S_FIN;
                                end else if (v_lit) begin
                                    n_term  = ST_DATA;
                                    n_state = S_FIN;
                                end
                            end
                        end
                    end
                end
            end
            S_RD: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = r_prod[HIST_AW-1:0] - r_off;
                n_state     = S_WR;
            end
            S_WR: begin
                if (r_cnt != 4'(OUT_LANES) || w_free) begin
                    v_acc = r_acc;
                    v_cnt = r_cnt;
                    if (r_cnt == 4'(OUT_LANES)) begin
                        n_ov  = 1'b1;
                        n_ob  = r_acc;
                        n_oc  = r_cnt;
                        n_os  = ST_DATA;
                        n_ol  = 1'b0;
                        v_acc = '0;
                        v_cnt = '0;
                    end
                    for (int i = 0; i < OUT_LANES; i++) begin
                        if (v_cnt[2:0] == 3'(i)) begin
                            v_acc[8*i +: 8] = i_ram_rdata;
                        end
                    end
                    n_acc       = v_acc;
                    n_cnt       = v_cnt + 4'd1;
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_prod[HIST_AW-1:0];
                    o_ram.wdata = i_ram_rdata;
                    n_prod      = r_prod + SIZE_W'(1);
                    n_len       = r_len - LEN_W'(1);
                    if (r_len == LEN_W'(1)) begin
                        n_state = S_FIN;
                        if (n_prod == i_exp_size) begin
                            n_cond = COND_DONE;
                            n_term = ST_COMPLETE;
                        end else if (r_ilast) begin
                            n_cond = COND_ERROR;
                            n_term = ST_TRUNC;
                        end else begin
                            n_term = ST_DATA;
                        end
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_FIN: begin
                if (w_free) begin
                    n_ov    = 1'b1;
                    n_ob    = r_acc;
                    n_oc    = r_cnt;
                    n_os    = r_term;
                    n_ol    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prod  <= '0;
            r_flags <= '0;
            r_tok   <= 4'd8;
            r_phase <= PH_TOKEN;
            r_off   <= '0;
            r_cond  <= COND_ACTIVE;
            r_len   <= '0;
            r_term  <= ST_DATA;
            r_ilast <= 1'b0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_prod  <= n_prod;
            r_flags <= n_flags;
            r_tok   <= n_tok;
            r_phase <= n_phase;
            r_off   <= n_off;
            r_cond  <= n_cond;
            r_len   <= n_len;
            r_term  <= n_term;
            r_ilast <= n_ilast;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_ob  <= n_ob;
        r_oc  <= n_oc;
        r_os  <= n_os;
        r_ol  <= n_ol;
    end

endmodule

>>> rtl/lzss_dewhiten_decompressor.sv
// Top level of the LZSS de-whitening decompressor.
//
// Input channel: one compressed byte per item on tdata, tuser starts a new
// stream, tlast marks the final compressed byte. Output channel: one result
// per item with up to eight decompressed bytes, a byte count and a status;
// tlast marks the final result caused by one input byte.
// Configuration writes take effect at the clock edge where i_cfg_we is high.
// The input side de-whitens each byte when enabled and places it in a
// two-entry queue, so input is taken while the decoder works. A flag or
// offset byte gives no result unless it ends the stream. A literal or an
// end-of-stream byte passes through the finish state to the output register.
// A match copies each byte by a registered history read in the read state
// and a write-back in the write state; the decoder takes no new queue item
// until the match is through. Results leave through an output register;
// when the receiver stalls, the decoder holds once that register is full
// and a full lane buffer or a finished byte waits, and the queue then fills
// and drops tready. Reset clears the stream state, arms a stream with the
// default keystream, and needs no clearing pass.
module lzss_dewhiten_decompressor
    import lzd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // in_byte
    input  logic                  i_s_axis_tuser,   // in_first
    input  logic                  i_s_axis_tlast,   // in_last
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [71:0]           o_m_axis_tdata,   // out_bytes, out_count, status, pad
    output logic                  o_m_axis_tlast,   // out_last
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [SIZE_W-1:0] r_exp_size;
    logic [31:0]       r_seed;
    logic              r_whiten;

    logic       w_q_full;
    logic       w_q_push;
    t_qitem     w_q_in;
    logic       w_q_valid;
    t_qitem     w_q_out;
    logic       w_q_pop;
    t_ram_req   w_ram;
    logic [7:0] w_rdata;
    logic [63:0] w_bytes;
    logic [3:0]  w_count;
    t_status     w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_size <= '0;
            r_seed     <= '0;
            r_whiten   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EXP_SIZE: r_exp_size <= i_cfg_data[SIZE_W-1:0];
                CFG_SEED:     r_seed     <= i_cfg_data[31:0];
                CFG_WHITEN:   r_whiten   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    lzd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_byte   (i_s_axis_tdata),
        .i_first  (i_s_axis_tuser),
        .i_last   (i_s_axis_tlast),
        .o_ready  (o_s_axis_tready),
        .i_seed   (r_seed),
        .i_whiten (r_whiten),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_q_item (w_q_in)
    );

    lzd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_q_in),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_out),
        .i_pop   (w_q_pop)
    );

    lzd_ram #(
        .WIDTH (8),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    lzd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_out),
        .o_q_pop     (w_q_pop),
        .i_exp_size  (r_exp_size),
        .o_ram       (w_ram),
        .i_ram_rdata (w_rdata),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_bytes     (w_bytes),
        .o_count     (w_count),
        .o_status    (w_status),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, w_status, w_count, w_bytes};

endmodule

>>> verif/lzss_dewhiten_decompressor_tb.sv
// Self-checking testbench for the LZSS de-whitening decompressor, with a built-in decoder predictor.
module lzss_dewhiten_decompressor_tb;
    import lzd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int LONG_HOLD      = 3000;

    typedef struct {
        bit [7:0] data;
        bit       first;
        bit       last;
    } t_byte_item;

    typedef struct {
        bit [63:0] bytes;
        bit [3:0]  count;
        t_status   status;
        bit        last;
    } t_chunk;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [71:0]           m_tdata;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    lzss_dewhiten_decompressor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Register mirror.
    bit [29:0] size_reg = '0;
    bit [31:0] seed_reg = '0;
    bit        whiten_reg = 1'b1;

    // Decoder state mirror.
    bit [7:0]  history [HIST_DEPTH];
    bit [31:0] ks;
    bit [29:0] produced;
    bit [7:0]  flags;
    bit [3:0]  tok_idx;
    t_phase    phase;
    bit [15:0] offset;
    t_cond     cond;

    t_byte_item compressed_q[$];
    t_chunk     chunk_q[$];
    int         mismatches = 0;
    int         bytes_queued = 0;

    // Generator side: its own keystream, used to whiten the bytes it queues.
    bit [31:0] gen_ks;

    function automatic bit [31:0] ks_next(bit [31:0] x);
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    function automatic void restart_stream();
        produced = '0;
        flags    = '0;
        tok_idx  = 4'd8;
        phase    = PH_TOKEN;
        offset   = '0;
        ks       = (seed_reg != 0) ? seed_reg : KS_DEFAULT;
        cond     = COND_ACTIVE;
    endfunction

    function automatic void decode_byte(bit [7:0] din, bit first, bit last);
        t_chunk    out_list[$];
        t_chunk    c;
        bit [63:0] lanes;
        int        nlanes;
        bit [7:0]  b;
        int        len;
        bit [7:0]  cb;
        t_status   term;
        t_status   err;

        lanes = '0;
        nlanes = 0;
        term = ST_DATA;
        err = ST_DATA;
        if (first) restart_stream();
        if (cond != COND_ACTIVE) return;
        ks = ks_next(ks);
        b = whiten_reg ? (din ^ ks[31:24]) : din;
        if (produced >= size_reg) begin
            cond = COND_ERROR;
            chunk_q.insert(chunk_q.size(), t_chunk'{64'd0, 4'd0, ST_UNEXP, 1'b1});
            return;
        end
        len = 0;
        case (phase)
            PH_TOKEN: begin
                if (tok_idx >= 8) begin
                    flags = b;
                    tok_idx = 0;
                end else if (flags[tok_idx[2:0]]) begin
                    offset = {8'd0, b};
                    phase = PH_OFF_HI;
                end else begin
                    len = -1;
                    tok_idx++;
                end
            end
            PH_OFF_HI: begin
                offset[15:8] = b;
                phase = PH_LENGTH;
            end
            default: begin
                phase = PH_TOKEN;
                tok_idx++;
                if (offset == 0 || {14'd0, offset} > produced) err = ST_BADREF;
                else if (longint'(produced) + b + 4 > longint'(size_reg)) err = ST_OVERLONG;
                if (err != ST_DATA) begin
                    cond = COND_ERROR;
                    chunk_q.insert(chunk_q.size(), t_chunk'{64'd0, 4'd0, err, 1'b1});
                    return;
                end
                len = int'(b) + 4;
            end
        endcase
        for (int k = 0; k < ((len < 0) ? 1 : len); k++) begin
            cb = (len < 0) ? b : history[16'(produced - {14'd0, offset})];
            history[produced[15:0]] = cb;
            produced = produced + 1'b1;
            lanes[8*nlanes +: 8] = cb;
            nlanes++;
            if (nlanes == OUT_LANES) begin
                out_list.insert(out_list.size(), t_chunk'{lanes, 4'd8, ST_DATA, 1'b0});
                lanes = '0;
                nlanes = 0;
            end
        end
        if (produced == size_reg) begin
            term = ST_COMPLETE;
            cond = COND_DONE;
        end else if (last) begin
            term = ST_TRUNC;
            cond = COND_ERROR;
        end
        if (nlanes > 0)
            out_list.insert(out_list.size(), t_chunk'{lanes, 4'(nlanes), ST_DATA, 1'b0});
        if (term != ST_DATA && out_list.size() == 0)
            out_list.insert(out_list.size(), t_chunk'{64'd0, 4'd0, ST_DATA, 1'b0});
        if (out_list.size() > 0) begin
            out_list[$].status = term;
            out_list[$].last = 1'b1;
        end
        foreach (out_list[i]) chunk_q.insert(chunk_q.size(), out_list[i]);
    endfunction

    function automatic int draw_gap(int n);
        if ((n / 40) % 4 == 3) return 0;
        return $urandom_range(0, 13);
    endfunction

    // Sender.
    int src_gap = 0;
    int src_sent = 0;
    always @(posedge i_clk) begin
        t_byte_item it;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            decode_byte(s_tdata, s_tuser, s_tlast);
            src_sent++;
            src_gap = draw_gap(src_sent);
            if (src_gap == 0 && compressed_q.size() > 0) begin
                it = compressed_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= it.data;
                s_tuser <= it.first;
                s_tlast <= it.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end else if (!s_tvalid) begin
            if (src_gap > 0) begin
                src_gap--;
            end else if (compressed_q.size() > 0) begin
                it = compressed_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= it.data;
                s_tuser <= it.first;
                s_tlast <= it.last;
            end
        end
    end

    // Receiver, with one long hold-off once the run is under way.
    int  rcv_gap = 0;
    int  rcv_hold = 0;
    int  results_seen = 0;
    bit  held_once = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (rcv_hold > 0) begin
            rcv_hold--;
            m_tready <= (rcv_hold == 0);
        end else if (m_tready && m_tvalid) begin
            results_seen++;
            if (results_seen == 60 && !held_once) begin
                held_once = 1'b1;
                rcv_hold = LONG_HOLD;
                m_tready <= 1'b0;
            end else begin
                rcv_gap = draw_gap(results_seen);
                m_tready <= (rcv_gap == 0);
            end
        end else if (!m_tready) begin
            if (rcv_gap > 0) rcv_gap--;
            else m_tready <= 1'b1;
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_chunk e;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (chunk_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: data=%h last=%b", m_tdata, m_tlast);
            end else begin
                e = chunk_q.pop_front();
                if (m_tdata[63:0] !== e.bytes || m_tdata[67:64] !== e.count ||
                    m_tdata[70:68] !== e.status || m_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected bytes=%h count=%0d status=%0d last=%b, got bytes=%h count=%0d status=%0d last=%b",
                                 e.bytes, e.count, e.status, e.last, m_tdata[63:0],
                                 m_tdata[67:64], m_tdata[70:68], m_tlast);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side and no configuration write.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        case (idx)
            CFG_EXP_SIZE: size_reg = value[29:0];
            CFG_SEED:     seed_reg = value;
            CFG_WHITEN:   whiten_reg = value[0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (compressed_q.size() > 0 || s_tvalid || chunk_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void send(bit [7:0] plain, bit first, bit last);
        if (first) gen_ks = (seed_reg != 0) ? seed_reg : KS_DEFAULT;
        gen_ks = ks_next(gen_ks);
        compressed_q.insert(compressed_q.size(),
                            t_byte_item'{whiten_reg ? (plain ^ gen_ks[31:24]) : plain,
                                         first, last});
        bytes_queued++;
    endfunction

    typedef enum int {
        GEN_CLEAN, GEN_TRUNC, GEN_BADREF, GEN_OVERLONG, GEN_ABORT, GEN_NOISE
    } t_gen_mode;

    // Builds a well-formed stream of n_out bytes ended per mode; GEN_NOISE sends only random bytes.
    function automatic void gen_stream(int n_out, t_gen_mode mode, int maxlen);
        int        p;
        int        nt;
        int        rem;
        int        cap;
        bit        fresh;
        bit        injected;
        bit [7:0]  fl;
        bit        is_match [8];
        bit [15:0] offs [8];
        bit [7:0]  lens [8];
        bit        fin;

        p = 0;
        fresh = 1'b1;
        injected = 1'b0;
        if (mode == GEN_NOISE) begin
            repeat ($urandom_range(1, 10)) begin
                send(8'($urandom), fresh, $urandom_range(0, 5) == 0);
                fresh = 1'b0;
            end
            return;
        end
        while (p < n_out || ((mode == GEN_BADREF || mode == GEN_OVERLONG) && !injected)) begin
            fl = 8'($urandom);
            nt = 0;
            for (int t = 0; t < 8; t++) begin
                rem = n_out - p;
                if (rem == 0) begin
                    if ((mode == GEN_BADREF || mode == GEN_OVERLONG) && !injected) begin
                        injected = 1'b1;
                        is_match[t] = 1'b1;
                        fl[t] = 1'b1;
                        lens[t] = 8'($urandom);
                        if (mode == GEN_BADREF)
                            offs[t] = ($urandom_range(0, 1) == 0) ? 16'd0 :
                                      16'(p + $urandom_range(1, 300));
                        else
                            offs[t] = 16'($urandom_range(1, p));
                        nt++;
                    end
                    break;
                end
                if (p > 0 && rem >= 4 && $urandom_range(0, 2) == 0) begin
                    cap = ($urandom_range(0, 9) == 0) ? 255 : maxlen;
                    if (cap > rem - 4) cap = rem - 4;
                    is_match[t] = 1'b1;
                    fl[t] = 1'b1;
                    offs[t] = 16'($urandom_range(1, (p > 64 && $urandom_range(0, 3) != 0) ?
                                                      64 : p));
                    lens[t] = 8'($urandom_range(0, cap));
                    p += lens[t] + 4;
                end else begin
                    is_match[t] = 1'b0;
                    fl[t] = 1'b0;
                    lens[t] = 8'($urandom);
                    p++;
                end
                nt++;
            end
            send(fl, fresh, 1'b0);
            fresh = 1'b0;
            for (int t = 0; t < nt; t++) begin
                fin = (t == nt - 1) && (p == n_out) && mode == GEN_CLEAN &&
                      $urandom_range(0, 1) == 0;
                if (is_match[t]) begin
                    send(offs[t][7:0], 1'b0, 1'b0);
                    send(offs[t][15:8], 1'b0, 1'b0);
                    send(lens[t], 1'b0, fin);
                end else begin
                    send(lens[t], 1'b0, fin);
                end
            end
        end
        if (mode == GEN_TRUNC) send(8'($urandom), 1'b0, 1'b1);
        repeat ($urandom_range(0, 2)) send(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
    endfunction

    initial begin
        int        sz;
        int        n_out;
        t_gen_mode mode;

        for (int i = 0; i < HIST_DEPTH; i++) history[i] = '0;
        restart_stream();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Stream armed by reset with zero expected size: any byte is unexpected.
        send(8'h00, 1'b0, 1'b0);
        send(8'hff, 1'b0, 1'b1);
        wait_idle();

        // Plain literals, a maximal self-overlapping match, then a wide offset beyond the output.
        write_reg(CFG_WHITEN, 32'd0);
        write_reg(CFG_EXP_SIZE, 32'd276);
        send(8'h02, 1'b1, 1'b0);
        send(8'hff, 1'b0, 1'b0);
        send(8'h01, 1'b0, 1'b0);
        send(8'h00, 1'b0, 1'b0);
        send(8'hff, 1'b0, 1'b0);
        send(8'h00, 1'b0, 1'b0);
        send(8'h00, 1'b0, 1'b0);
        send(8'h80, 1'b0, 1'b0);
        send(8'h55, 1'b0, 1'b0);
        send(8'haa, 1'b0, 1'b0);
        send(8'h01, 1'b0, 1'b0);
        send(8'h7f, 1'b0, 1'b0);
        send(8'hfe, 1'b0, 1'b0);
        send(8'h33, 1'b0, 1'b0);
        send(8'h01, 1'b0, 1'b0);
        send(8'h0c, 1'b0, 1'b0);
        send(8'h01, 1'b0, 1'b0);
        send(8'h00, 1'b0, 1'b0);
        send(8'h00, 1'b0, 1'b0);
        send(8'h11, 1'b0, 1'b0);
        send(8'h22, 1'b0, 1'b0);
        send(8'h44, 1'b0, 1'b0);
        send(8'h88, 1'b0, 1'b1);
        send(8'h01, 1'b1, 1'b0);
        send(8'h00, 1'b0, 1'b0);
        send(8'h00, 1'b0, 1'b0);
        send(8'h05, 1'b0, 1'b0);
        wait_idle();

        write_reg(CFG_EXP_SIZE, 32'd0);
        send(8'h5a, 1'b1, 1'b0);
        wait_idle();

        write_reg(CFG_WHITEN, 32'd1);
        write_reg(CFG_SEED, 32'hffff_ffff);
        write_reg(CFG_EXP_SIZE, 32'h2000_0000);
        gen_stream(20, GEN_TRUNC, 12);
        wait_idle();

        while (bytes_queued < 360) begin
            sz = ($urandom_range(0, 5) == 0) ? $urandom_range(200, 300) :
                                               $urandom_range(4, 120);
            write_reg(CFG_EXP_SIZE, 32'(sz));
            case ($urandom_range(0, 3))
                0: write_reg(CFG_SEED, 32'd0);
                1: write_reg(CFG_SEED, 32'hffff_ffff);
                default: write_reg(CFG_SEED, $urandom);
            endcase
            write_reg(CFG_WHITEN, 32'($urandom_range(0, 3) != 0));
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 11))
                    0, 1, 2, 3, 4: mode = GEN_CLEAN;
                    5, 6:          mode = GEN_TRUNC;
                    7:             mode = GEN_BADREF;
                    8:             mode = GEN_OVERLONG;
                    9, 10:         mode = GEN_ABORT;
                    default:       mode = GEN_NOISE;
                endcase
                n_out = (mode == GEN_CLEAN) ? sz : sz - $urandom_range(1, 3);
                gen_stream(n_out, mode, 12);
            end
            wait_idle();
        end

        wait_idle();
        if (mismatches == 0 && chunk_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
